// ===== sv/mefr_pkg.sv =====
// shared types, constants and register codes for the manchester edge frame receiver
// no dependencies; imported by the interfaces and every module of the block
package mefr_pkg;

   localparam int ADDR_BITS        = 5;
   localparam int ADDR_CNT_W       = $clog2(ADDR_BITS + 1);
   localparam int ADDR_IDX_W       = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;
   localparam int MAX_PAYLOAD_BITS = 2048;
   localparam int PCOUNT_W         = $clog2(MAX_PAYLOAD_BITS + 1);
   localparam int PIDX_W           = $clog2(MAX_PAYLOAD_BITS);

   localparam int TICK_W   = 32;
   localparam int WINDOW_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WINDOW_W-1:0]  LONG_MIN_RESET  = 16'd10000;
   localparam logic [WINDOW_W-1:0]  LONG_MAX_RESET  = 16'd20000;
   localparam logic [WINDOW_W-1:0]  SHORT_MIN_RESET = 16'd1000;
   localparam logic [WINDOW_W-1:0]  SHORT_MAX_RESET = 16'd8000;
   localparam logic [ADDR_BITS-1:0] OWN_ADDR_RESET  = 5'd21;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_MIN    = 3'd0,
      CSR_LONG_MAX    = 3'd1,
      CSR_SHORT_MIN   = 3'd2,
      CSR_SHORT_MAX   = 3'd3,
      CSR_OWN_ADDRESS = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      FIELD_DEST    = 2'd0,
      FIELD_SRC     = 2'd1,
      FIELD_PAYLOAD = 2'd2
   } field_type;

   typedef struct packed {
      logic [WINDOW_W-1:0] long_min;
      logic [WINDOW_W-1:0] long_max;
      logic [WINDOW_W-1:0] short_min;
      logic [WINDOW_W-1:0] short_max;
   } window_cfg_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic eof;
      logic got_bit;
      logic level;
   } token_type;

   typedef struct packed {
      logic                 bit_valid;
      logic                 bit_value;
      field_type            field;
      logic [PIDX_W-1:0]    payload_index;
      logic [ADDR_BITS-1:0] dest_address;
      logic [ADDR_BITS-1:0] src_address;
      logic                 dest_match;
      logic                 overflow;
      logic                 frame_done;
      logic [PCOUNT_W-1:0]  payload_length;
   } result_type;

endpackage

// ===== sv/mefr_channels.sv =====
// valid/ready channel interfaces: edge requests, decoded results, register writes
// depends on mefr_pkg
interface mefr_req_if import mefr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic              level;
   logic [TICK_W-1:0] tick;

   modport source (output valid, output cmd, output level, output tick, input ready);
   modport sink   (input valid, input cmd, input level, input tick, output ready);
endinterface

interface mefr_rsp_if import mefr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 bit_valid;
   logic                 bit_value;
   logic [1:0]           field;
   logic [PIDX_W-1:0]    payload_index;
   logic [ADDR_BITS-1:0] dest_address;
   logic [ADDR_BITS-1:0] src_address;
   logic                 dest_match;
   logic                 overflow;
   logic                 frame_done;
   logic [PCOUNT_W-1:0]  payload_length;

   modport source (output valid, output bit_valid, output bit_value, output field,
                   output payload_index, output dest_address, output src_address,
                   output dest_match, output overflow, output frame_done,
                   output payload_length, input ready);
   modport sink   (input valid, input bit_valid, input bit_value, input field,
                   input payload_index, input dest_address, input src_address,
                   input dest_match, input overflow, input frame_done,
                   input payload_length, output ready);
endinterface

interface mefr_csr_if import mefr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/manchester_edge_frame_receiver.sv =====
// path: a transaction accepted on req_bus is registered in the token queue, then in the result register on rsp_bus
// throughput: one transaction per cycle while the token queue is not full; a four-entry token queue and the result
// register let the front end keep accepting while a result waits to be taken
// reset: synchronous, clears edge timing, pair and field counters, queue and result
// valid, and loads the window and address registers with their defaults
module manchester_edge_frame_receiver import mefr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mefr_req_if.sink    req_bus,
   mefr_rsp_if.source  rsp_bus,
   mefr_csr_if.sink    csr_bus
);

   window_cfg_type       win_ff;
   logic [ADDR_BITS-1:0] own_address_ff;
   logic                 q_full, q_push, q_pop, q_head_valid;
   token_type            q_token, q_head_token;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff.long_min  <= LONG_MIN_RESET;
         win_ff.long_max  <= LONG_MAX_RESET;
         win_ff.short_min <= SHORT_MIN_RESET;
         win_ff.short_max <= SHORT_MAX_RESET;
         own_address_ff   <= OWN_ADDR_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_LONG_MIN:    win_ff.long_min  <= csr_bus.data;
            CSR_LONG_MAX:    win_ff.long_max  <= csr_bus.data;
            CSR_SHORT_MIN:   win_ff.short_min <= csr_bus.data;
            CSR_SHORT_MAX:   win_ff.short_max <= csr_bus.data;
            CSR_OWN_ADDRESS: own_address_ff   <= csr_bus.data[ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   mefr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .win     (win_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_token (q_token)
   );

   mefr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_token),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_token (q_head_token)
   );

   mefr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .own_address (own_address_ff),
      .head_valid  (q_head_valid),
      .head_token  (q_head_token),
      .pop         (q_pop),
      .rsp         (rsp_bus)
   );

endmodule

// ===== sv/mefr_front.sv =====
// front end: accepts edge and end-of-frame transactions, times the interval and pairs short intervals
// depends on mefr_pkg and mefr_req_if; feeds mefr_queue
module mefr_front import mefr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   mefr_req_if.sink       req,
   input  window_cfg_type win,
   input  logic           q_full,
   output logic           q_push,
   output token_type      q_token
);

   logic              seen_edge_ff, seen_edge_in;
   logic [TICK_W-1:0] last_tick_ff, last_tick_in;
   logic [1:0]        pair_count_ff, pair_count_in;
   logic [TICK_W-1:0] diff;
   logic [1:0]        pair_inc;
   logic              long_hit, short_hit, got_bit;
   logic              accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      // first edge counts as a one-tick interval
      diff      = seen_edge_ff ? (req.tick - last_tick_ff) : TICK_W'(1);
      long_hit  = (diff >= TICK_W'(win.long_min)) && (diff <= TICK_W'(win.long_max));
      short_hit = (diff >= TICK_W'(win.short_min)) && (diff <= TICK_W'(win.short_max));
      pair_inc  = pair_count_ff + 2'd1;
      got_bit   = 1'b0;
      pair_count_in = pair_count_ff;
      if (long_hit) begin
         got_bit = 1'b1;
      end else if (short_hit) begin
         if (pair_inc >= 2'd2) begin
            pair_count_in = 2'd0;
            got_bit       = 1'b1;
         end else begin
            pair_count_in = pair_inc;
         end
      end
      seen_edge_in = 1'b1;
      last_tick_in = req.tick;
   end

   always_comb begin
      q_token.eof     = req.cmd;
      q_token.got_bit = got_bit && !req.cmd;
      q_token.level   = req.level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_edge_ff  <= 1'b0;
         last_tick_ff  <= '0;
         pair_count_ff <= '0;
      end else if (accept && !req.cmd) begin
         seen_edge_ff  <= seen_edge_in;
         last_tick_ff  <= last_tick_in;
         pair_count_ff <= pair_count_in;
      end
   end

   a_edge_sets_seen: assert property (@(posedge clock) disable iff (reset)
      (accept && !req.cmd) |=> seen_edge_ff)
      else $error("seen_edge not set after an edge transaction");

   a_pair_bound: assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= 2'd1)
      else $error("pair count left a completed pair pending");

endmodule

// ===== sv/mefr_queue.sv =====
// short token queue between the classifying front end and the frame back end
// depends on mefr_pkg
module mefr_queue import mefr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_token,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output token_type head_token
);

   token_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_token = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_token;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("token queue count beyond its depth");

endmodule

// ===== sv/mefr_back.sv =====
// back end: assigns decoded bits to address and payload fields, drives the result register
// depends on mefr_pkg and mefr_rsp_if; drains mefr_queue
module mefr_back import mefr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ADDR_BITS-1:0] own_address,
   input  logic                 head_valid,
   input  token_type            head_token,
   output logic                 pop,
   mefr_rsp_if.source           rsp
);

   logic [ADDR_CNT_W-1:0] dest_count_ff, dest_count_in, dest_count_upd;
   logic [ADDR_CNT_W-1:0] src_count_ff, src_count_in, src_count_upd;
   logic [ADDR_BITS-1:0]  dest_bits_ff, dest_bits_in, dest_bits_upd;
   logic [ADDR_BITS-1:0]  src_bits_ff, src_bits_in, src_bits_upd;
   logic [PCOUNT_W-1:0]   payload_count_ff, payload_count_in, payload_count_upd;
   logic                  overflowed_ff, overflowed_in, overflowed_upd;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, rsp_data_in;
   logic [ADDR_IDX_W-1:0] dest_pos, src_pos;

   // result register refills whenever a token is waiting and the register is empty or being taken
   assign pop = head_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      dest_pos = ADDR_IDX_W'(ADDR_CNT_W'(ADDR_BITS - 1) - dest_count_ff);
      src_pos  = ADDR_IDX_W'(ADDR_CNT_W'(ADDR_BITS - 1) - src_count_ff);

      dest_count_upd    = dest_count_ff;
      src_count_upd     = src_count_ff;
      dest_bits_upd     = dest_bits_ff;
      src_bits_upd      = src_bits_ff;
      payload_count_upd = payload_count_ff;
      overflowed_upd    = overflowed_ff;

      rsp_data_in               = '0;
      rsp_data_in.field         = FIELD_DEST;
      rsp_data_in.frame_done    = head_token.eof;

      if (head_token.got_bit) begin
         rsp_data_in.bit_valid = 1'b1;
         rsp_data_in.bit_value = head_token.level;
         if (dest_count_ff < ADDR_CNT_W'(ADDR_BITS)) begin
            dest_bits_upd[dest_pos] = dest_bits_ff[dest_pos] | head_token.level;
            dest_count_upd          = dest_count_ff + ADDR_CNT_W'(1);
            rsp_data_in.field       = FIELD_DEST;
         end else if (src_count_ff < ADDR_CNT_W'(ADDR_BITS)) begin
            src_bits_upd[src_pos] = src_bits_ff[src_pos] | head_token.level;
            src_count_upd         = src_count_ff + ADDR_CNT_W'(1);
            rsp_data_in.field     = FIELD_SRC;
         end else begin
            rsp_data_in.field = FIELD_PAYLOAD;
            if (payload_count_ff < PCOUNT_W'(MAX_PAYLOAD_BITS)) begin
               rsp_data_in.payload_index = payload_count_ff[PIDX_W-1:0];
               payload_count_upd         = payload_count_ff + PCOUNT_W'(1);
            end else begin
               // payload beyond capacity is reported but not stored
               overflowed_upd = 1'b1;
            end
         end
      end

      rsp_data_in.dest_address   = dest_bits_upd;
      rsp_data_in.src_address    = src_bits_upd;
      rsp_data_in.dest_match     = (dest_count_upd == ADDR_CNT_W'(ADDR_BITS)) &&
                                   (dest_bits_upd == own_address);
      rsp_data_in.overflow       = overflowed_upd;
      rsp_data_in.payload_length = payload_count_upd;

      // end of frame reports the ending frame, then clears the field counters
      if (head_token.eof) begin
         dest_count_in    = '0;
         src_count_in     = '0;
         dest_bits_in     = '0;
         src_bits_in      = '0;
         payload_count_in = '0;
         overflowed_in    = 1'b0;
      end else begin
         dest_count_in    = dest_count_upd;
         src_count_in     = src_count_upd;
         dest_bits_in     = dest_bits_upd;
         src_bits_in      = src_bits_upd;
         payload_count_in = payload_count_upd;
         overflowed_in    = overflowed_upd;
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_count_ff    <= '0;
         src_count_ff     <= '0;
         dest_bits_ff     <= '0;
         src_bits_ff      <= '0;
         payload_count_ff <= '0;
         overflowed_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            dest_count_ff    <= dest_count_in;
            src_count_ff     <= src_count_in;
            dest_bits_ff     <= dest_bits_in;
            src_bits_ff      <= src_bits_in;
            payload_count_ff <= payload_count_in;
            overflowed_ff    <= overflowed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.bit_valid      = rsp_data_ff.bit_valid;
   assign rsp.bit_value      = rsp_data_ff.bit_value;
   assign rsp.field          = rsp_data_ff.field;
   assign rsp.payload_index  = rsp_data_ff.payload_index;
   assign rsp.dest_address   = rsp_data_ff.dest_address;
   assign rsp.src_address    = rsp_data_ff.src_address;
   assign rsp.dest_match     = rsp_data_ff.dest_match;
   assign rsp.overflow       = rsp_data_ff.overflow;
   assign rsp.frame_done     = rsp_data_ff.frame_done;
   assign rsp.payload_length = rsp_data_ff.payload_length;

   a_eof_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && head_token.eof) |=>
         (dest_count_ff == '0) && (payload_count_ff == '0) && !overflowed_ff)
      else $error("end of frame did not clear the field counters");

endmodule
